// File: src/hkr_pkg.sv
// Shared types and constants for the HID keyboard report builder.
package hkr_pkg;

   localparam logic [7:0] MOD_MASK      = 8'hF8;
   localparam logic [7:0] MOD_BASE      = 8'hE0;
   localparam logic [7:0] MOD_BIT       = 8'h07;
   localparam logic [7:0] ROLLOVER_CODE = 8'h01;
   localparam logic [7:0] EMPTY_CODE    = 8'h00;
   localparam int         MAX_SLOTS     = 6;

   typedef struct packed {
      logic [7:0] key_code;
      logic       released;
   } req_type;

   typedef struct packed {
      logic [7:0] modifier_bits;
      logic [7:0] slot0;
      logic [7:0] slot1;
      logic [7:0] slot2;
      logic [7:0] slot3;
      logic [7:0] slot4;
      logic [7:0] slot5;
      logic       rollover_error;
   } rsp_type;

endpackage

// File: src/hid_keyboard_report_builder.sv
// Top level of the HID boot keyboard report builder.
// Modifier and zero codes go straight to the report; a key event scans one held entry per cycle
// to a hit or the end, appends a missed press if not full, compacts the table on a released hit.
// Throughput: one request at a time; busy stays high until the report strobe is issued.
// The report is registered and strobed on rsp_valid for one cycle; the receiver cannot stall.
// Reset clears the held-key table, the held count and the modifier byte.
module hid_keyboard_report_builder #(
   parameter int TRACKED_KEYS = 16,
   parameter int REPORT_SLOTS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hkr_pkg::req_type  req_data,
   output logic              rsp_valid,
   output hkr_pkg::rsp_type  rsp_data
);

   localparam int ADDR_W = $clog2(TRACKED_KEYS);
   localparam int CNT_W  = $clog2(TRACKED_KEYS + 1);

   logic                         report_go;
   logic [CNT_W-1:0]             held_count;
   logic [7:0]                   modifier_state;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [7:0]                   wr_data;
   logic [ADDR_W-1:0]            rd_addr;
   logic [7:0]                   rd_data;
   logic [REPORT_SLOTS-1:0][7:0] slot_keys;
   logic [hkr_pkg::MAX_SLOTS-1:0][7:0] slot_vals;
   logic                         roll;

   logic             rsp_valid_ff, rsp_valid_in;
   hkr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   hkr_seq #(
      .TRACKED_KEYS (TRACKED_KEYS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_data       (req_data),
      .busy           (busy),
      .report_go      (report_go),
      .held_count     (held_count),
      .modifier_state (modifier_state),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   hkr_table #(
      .TRACKED_KEYS (TRACKED_KEYS),
      .REPORT_SLOTS (REPORT_SLOTS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .slot_keys (slot_keys)
   );

   assign roll = (held_count > CNT_W'(REPORT_SLOTS));

   always_comb begin
      for (int j = 0; j < hkr_pkg::MAX_SLOTS; j++) begin
         slot_vals[j] = hkr_pkg::EMPTY_CODE;
      end
      for (int j = 0; j < REPORT_SLOTS; j++) begin
         slot_vals[j] = roll ? hkr_pkg::ROLLOVER_CODE : slot_keys[j];
      end
   end

   always_comb begin
      rsp_valid_in                = report_go;
      rsp_data_in                 = rsp_data_ff;
      if (report_go) begin
         rsp_data_in.modifier_bits  = modifier_state;
         rsp_data_in.slot0          = slot_vals[0];
         rsp_data_in.slot1          = slot_vals[1];
         rsp_data_in.slot2          = slot_vals[2];
         rsp_data_in.slot3          = slot_vals[3];
         rsp_data_in.slot4          = slot_vals[4];
         rsp_data_in.slot5          = slot_vals[5];
         rsp_data_in.rollover_error = roll;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/hkr_table.sv
// Held-key table: one write port, one scan read port, fixed taps for the report slots.
module hkr_table #(
   parameter int TRACKED_KEYS = 16,
   parameter int REPORT_SLOTS = 6,
   localparam int ADDR_W = $clog2(TRACKED_KEYS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic [7:0]                       wr_data,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic [7:0]                       rd_data,
   output logic [REPORT_SLOTS-1:0][7:0]     slot_keys
);

   logic [7:0] keys_ff [TRACKED_KEYS];
   logic [7:0] keys_in [TRACKED_KEYS];

   always_comb begin
      for (int i = 0; i < TRACKED_KEYS; i++) begin
         keys_in[i] = keys_ff[i];
      end
      if (wr_en) begin
         keys_in[wr_addr] = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TRACKED_KEYS; i++) begin
         if (reset) begin
            keys_ff[i] <= hkr_pkg::EMPTY_CODE;
         end else begin
            keys_ff[i] <= keys_in[i];
         end
      end
   end

   assign rd_data = keys_ff[rd_addr];

   always_comb begin
      for (int j = 0; j < REPORT_SLOTS; j++) begin
         slot_keys[j] = keys_ff[j];
      end
   end

endmodule

// File: src/hkr_seq.sv
// Event sequencer: scans the held-key table with one shared comparator and applies the update.
module hkr_seq #(
   parameter int TRACKED_KEYS = 16,
   localparam int ADDR_W = $clog2(TRACKED_KEYS),
   localparam int CNT_W  = $clog2(TRACKED_KEYS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  hkr_pkg::req_type    req_data,
   output logic                busy,
   output logic                report_go,
   output logic [CNT_W-1:0]    held_count,
   output logic [7:0]          modifier_state,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [7:0]          wr_data,
   output logic [ADDR_W-1:0]   rd_addr,
   input  logic [7:0]          rd_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_MOVE   = 3'd2;
   localparam logic [2:0] ST_CLEAR  = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;

   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(TRACKED_KEYS);

   logic [2:0]        state_ff, state_in;
   logic [7:0]        code_ff, code_in;
   logic              rel_ff, rel_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] match_ff, match_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        mod_ff, mod_in;
   logic [CNT_W-1:0]  last;
   logic [7:0]        mod_bit;

   assign last    = count_ff - CNT_W'(1);
   assign mod_bit = 8'd1 << (req_data.key_code & hkr_pkg::MOD_BIT);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      rel_in   = rel_ff;
      idx_in   = idx_ff;
      match_in = match_ff;
      count_in = count_ff;
      mod_in   = mod_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[ADDR_W-1:0];
      wr_data  = code_ff;
      rd_addr  = idx_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               code_in = req_data.key_code;
               rel_in  = req_data.released;
               idx_in  = '0;
               if ((req_data.key_code & hkr_pkg::MOD_MASK) == hkr_pkg::MOD_BASE) begin
                  mod_in   = req_data.released ? (mod_ff & ~mod_bit) : (mod_ff | mod_bit);
                  state_in = ST_REPORT;
               end else if (req_data.key_code == hkr_pkg::EMPTY_CODE) begin
                  state_in = ST_REPORT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff < count_ff) begin
               if (rd_data == code_ff) begin
                  match_in = idx_ff[ADDR_W-1:0];
                  state_in = rel_ff ? ST_MOVE : ST_REPORT;
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
            end else begin
               if (!rel_ff && (count_ff < COUNT_MAX)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_REPORT;
            end
         end
         ST_MOVE: begin
            rd_addr  = last[ADDR_W-1:0];
            wr_en    = 1'b1;
            wr_addr  = match_ff;
            wr_data  = rd_data;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = last[ADDR_W-1:0];
            wr_data  = hkr_pkg::EMPTY_CODE;
            count_in = last;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         mod_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mod_ff   <= mod_in;
      end
      code_ff  <= code_in;
      rel_ff   <= rel_in;
      idx_ff   <= idx_in;
      match_ff <= match_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign report_go      = (state_ff == ST_REPORT);
   assign held_count     = count_ff;
   assign modifier_state = mod_ff;

endmodule
